>>> design/tbrl_pkg.sv
// shared types and constants for the token bucket rate limiter
`timescale 1ns / 1ps

package tbrl_pkg;

   // fixed field widths of the request, response and register ports
   localparam int OPCODE_W    = 1;
   localparam int COUNT_W     = 16;
   localparam int TIMEOUT_W   = 31;
   localparam int OUT_TIME_W  = 48;
   localparam int IV_W        = 32;
   localparam int MAXP_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   // milliseconds to microseconds, and the bits its product adds
   localparam int US_PER_MS   = 1000;
   localparam int US_PER_MS_W = 10;

   // register reset values
   localparam logic [IV_W-1:0]   INTERVAL_RESET   = 32'd1000000;
   localparam logic [MAXP_W-1:0] MAX_STORED_RESET = 16'd0;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STORED = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ACQUIRE     = 1'b0,
      OP_TRY_ACQUIRE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SPEND,
      ST_MULTIPLY,
      ST_REPLY
   } state_type;

   typedef enum logic {
      MODE_DIVIDE,
      MODE_MULTIPLY
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_ctrl_type;

endpackage

>>> design/tbrl_req_if.sv
// request channel: opcode, permit count, timeout and present time
`timescale 1ns / 1ps

interface tbrl_req_if;
   logic                               valid;
   logic                               ready;
   logic [tbrl_pkg::OPCODE_W-1:0]      opcode;
   logic [tbrl_pkg::COUNT_W-1:0]       permit_count;
   logic [tbrl_pkg::TIMEOUT_W-1:0]     timeout_ms;
   logic [tbrl_pkg::OUT_TIME_W-1:0]    now_us;

   modport source (output valid, opcode, permit_count, timeout_ms, now_us, input ready);
   modport sink   (input valid, opcode, permit_count, timeout_ms, now_us, output ready);
endinterface

>>> design/tbrl_rsp_if.sv
// response channel: grant flag and wait time
`timescale 1ns / 1ps

interface tbrl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            granted;
   logic [tbrl_pkg::OUT_TIME_W-1:0] wait_us;

   modport source (output valid, granted, wait_us, input ready);
   modport sink   (input valid, granted, wait_us, output ready);
endinterface

>>> design/token_bucket_rate_limiter_unit.sv
// token bucket rate limiter top level: sequencer, bucket state and registers
`timescale 1ns / 1ps
// accepted request: check, a divide (refill) only when now is past the next free time, spend,
//   multiply and reply; DIV_N = TIME_BITS + FRAC_BITS, MUL_N = min(PERMIT_BITS,16) + FRAC_BITS
// refused try-acquire requests go from check straight to reply
// one request at a time: a new one is taken only back in idle, and later while a reply waits
// reset is synchronous, active high: bucket empty, next free time zero, registers at defaults

module token_bucket_rate_limiter_unit #(
   parameter int TIME_BITS   = 48,
   parameter int FRAC_BITS   = 16,
   parameter int PERMIT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   tbrl_req_if.sink                           req_ch,
   tbrl_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_en,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int CNT_W   = (PERMIT_BITS < tbrl_pkg::COUNT_W) ? PERMIT_BITS : tbrl_pkg::COUNT_W;
   localparam int NOW_W   = (TIME_BITS < tbrl_pkg::OUT_TIME_W) ? TIME_BITS
                                                               : tbrl_pkg::OUT_TIME_W;
   localparam int WANT_W  = CNT_W + FRAC_BITS;
   localparam int BANK_W  = tbrl_pkg::MAXP_W + FRAC_BITS;
   localparam int DIV_N   = TIME_BITS + FRAC_BITS;
   localparam int MUL_N   = WANT_W;
   localparam int OPW     = (DIV_N > MUL_N) ? DIV_N : MUL_N;
   localparam int ACC_W   = MUL_N + tbrl_pkg::IV_W;
   localparam int LIMIT_W = tbrl_pkg::TIMEOUT_W + tbrl_pkg::US_PER_MS_W;
   localparam int CMP_W   = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;
   localparam int SPEND_W = (WANT_W > BANK_W) ? WANT_W : BANK_W;
   localparam int PUSH_W  = ACC_W - FRAC_BITS;
   localparam int SAT_W   = ((PUSH_W > TIME_BITS) ? PUSH_W : TIME_BITS) + 1;

   localparam logic [SAT_W-1:0] TIME_MAX = SAT_W'({TIME_BITS{1'b1}});

   // state and registers
   tbrl_pkg::state_type         state_ff, state_in;
   tbrl_pkg::opcode_type        op_ff, op_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [TIME_BITS-1:0]        now_ff, now_in;
   logic [LIMIT_W-1:0]          limit_ff, limit_in;
   logic [TIME_BITS-1:0]        nft_ff, nft_in;
   logic [BANK_W-1:0]           banked_ff, banked_in;
   logic                        res_granted_ff, res_granted_in;
   logic [TIME_BITS-1:0]        wait_ff, wait_in;
   logic [tbrl_pkg::IV_W-1:0]   interval_ff, interval_in;
   logic [tbrl_pkg::MAXP_W-1:0] maxp_ff, maxp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_granted_ff, rsp_granted_in;
   logic [tbrl_pkg::OUT_TIME_W-1:0] rsp_wait_ff, rsp_wait_in;

   // datapath temporaries
   logic [tbrl_pkg::IV_W-1:0] iv_eff;
   logic                      behind;
   logic [TIME_BITS-1:0]      diff;
   logic                      refuse;
   logic [DIV_N-1:0]          dividend;
   logic [BANK_W-1:0]         cap;
   logic                      q_high;
   logic [BANK_W:0]           refill_sum;
   logic [WANT_W-1:0]         want;
   logic [SPEND_W-1:0]        used;
   logic [WANT_W-1:0]         fresh;
   logic [SAT_W-1:0]          push_total;
   logic [OPW-1:0]            operand;

   tbrl_pkg::unit_ctrl_type   unit_ctrl;
   logic                      unit_busy;
   logic [DIV_N-1:0]          quotient;
   logic [ACC_W-1:0]          product;

   tbrl_serial_unit #(
      .DIV_N (DIV_N),
      .MUL_N (MUL_N)
   ) u_serial (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (unit_ctrl),
      .operand  (operand),
      .divisor  (iv_eff),
      .busy     (unit_busy),
      .quotient (quotient),
      .product  (product)
   );

   assign req_ch.ready   = (state_ff == tbrl_pkg::ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.granted = rsp_granted_ff;
   assign rsp_ch.wait_us = rsp_wait_ff;

   // shared arithmetic terms
   always_comb begin
      iv_eff   = (interval_ff == '0) ? tbrl_pkg::IV_W'(1) : interval_ff;
      behind   = (nft_ff > now_ff);
      diff     = nft_ff - now_ff;
      refuse   = (op_ff == tbrl_pkg::OP_TRY_ACQUIRE) && behind &&
                 (CMP_W'(diff) > CMP_W'(limit_ff));
      dividend = DIV_N'(now_ff - nft_ff) << FRAC_BITS;
      cap      = BANK_W'(maxp_ff) << FRAC_BITS;

      // refill quotient clipped to the bucket ceiling
      q_high     = ((quotient >> BANK_W) != '0);
      refill_sum = {1'b0, banked_ff} + {1'b0, quotient[BANK_W-1:0]};

      // banked permits go first, the rest are fresh
      want  = WANT_W'(count_ff) << FRAC_BITS;
      used  = (SPEND_W'(want) < SPEND_W'(banked_ff)) ? SPEND_W'(want) : SPEND_W'(banked_ff);
      fresh = want - WANT_W'(used);

      // next free time plus fresh push, saturating at the time width
      push_total = SAT_W'(nft_ff) + SAT_W'(product >> FRAC_BITS);
   end

   // sequencer: next state, register updates and unit control
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      now_in         = now_ff;
      limit_in       = limit_ff;
      nft_in         = nft_ff;
      banked_in      = banked_ff;
      res_granted_in = res_granted_ff;
      wait_in        = wait_ff;
      interval_in    = interval_ff;
      maxp_in        = maxp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_wait_in    = rsp_wait_ff;
      unit_ctrl.start = 1'b0;
      unit_ctrl.mode  = tbrl_pkg::MODE_DIVIDE;
      operand         = OPW'(dividend) << (OPW - DIV_N);

      // register writes
      if (csr_write_en) begin
         unique case (csr_index)
            tbrl_pkg::CSR_INTERVAL:   interval_in = csr_write_data[tbrl_pkg::IV_W-1:0];
            tbrl_pkg::CSR_MAX_STORED: maxp_in     = csr_write_data[tbrl_pkg::MAXP_W-1:0];
            default:                  ;
         endcase
      end

      unique case (state_ff)
         tbrl_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = tbrl_pkg::opcode_type'(req_ch.opcode);
               count_in = req_ch.permit_count[CNT_W-1:0];
               now_in   = TIME_BITS'(req_ch.now_us[NOW_W-1:0]);
               limit_in = LIMIT_W'(req_ch.timeout_ms) * LIMIT_W'(tbrl_pkg::US_PER_MS);
               state_in = tbrl_pkg::ST_CHECK;
            end
         end
         tbrl_pkg::ST_CHECK: begin
            if (refuse) begin
               res_granted_in = 1'b0;
               wait_in        = '0;
               state_in       = tbrl_pkg::ST_REPLY;
            end else begin
               res_granted_in = 1'b1;
               if (now_ff > nft_ff) begin
                  unit_ctrl.start = 1'b1;
                  unit_ctrl.mode  = tbrl_pkg::MODE_DIVIDE;
                  state_in        = tbrl_pkg::ST_DIVIDE;
               end else begin
                  state_in = tbrl_pkg::ST_SPEND;
               end
            end
         end
         tbrl_pkg::ST_DIVIDE: begin
            if (!unit_busy) begin
               if (q_high || (refill_sum > {1'b0, cap})) begin
                  banked_in = cap;
               end else begin
                  banked_in = refill_sum[BANK_W-1:0];
               end
               nft_in   = now_ff;
               state_in = tbrl_pkg::ST_SPEND;
            end
         end
         tbrl_pkg::ST_SPEND: begin
            wait_in         = behind ? diff : '0;
            banked_in       = banked_ff - BANK_W'(used);
            unit_ctrl.start = 1'b1;
            unit_ctrl.mode  = tbrl_pkg::MODE_MULTIPLY;
            operand         = OPW'(fresh) << (OPW - MUL_N);
            state_in        = tbrl_pkg::ST_MULTIPLY;
         end
         tbrl_pkg::ST_MULTIPLY: begin
            if (!unit_busy) begin
               nft_in   = (push_total > TIME_MAX) ? {TIME_BITS{1'b1}}
                                                  : push_total[TIME_BITS-1:0];
               state_in = tbrl_pkg::ST_REPLY;
            end
         end
         tbrl_pkg::ST_REPLY: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_wait_in    = tbrl_pkg::OUT_TIME_W'(wait_ff[NOW_W-1:0]);
               state_in       = tbrl_pkg::ST_IDLE;
            end
         end
         default: state_in = tbrl_pkg::ST_IDLE;
      endcase
   end

   // state register and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbrl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nft_ff       <= '0;
         banked_ff    <= '0;
         interval_ff  <= tbrl_pkg::INTERVAL_RESET;
         maxp_ff      <= tbrl_pkg::MAX_STORED_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nft_ff       <= nft_in;
         banked_ff    <= banked_in;
         interval_ff  <= interval_in;
         maxp_ff      <= maxp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      count_ff       <= count_in;
      now_ff         <= now_in;
      limit_ff       <= limit_in;
      res_granted_ff <= res_granted_in;
      wait_ff        <= wait_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

endmodule

>>> design/tbrl_serial_unit.sv
// bit-serial shared unit: restoring divide or shift-add multiply by the interval
`timescale 1ns / 1ps

module tbrl_serial_unit #(
   parameter int DIV_N = 64,
   parameter int MUL_N = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbrl_pkg::unit_ctrl_type       ctrl,
   input  logic [((DIV_N > MUL_N) ? DIV_N : MUL_N)-1:0] operand,
   input  logic [tbrl_pkg::IV_W-1:0]     divisor,
   output logic                          busy,
   output logic [DIV_N-1:0]              quotient,
   output logic [MUL_N+tbrl_pkg::IV_W-1:0] product
);

   localparam int OPW    = (DIV_N > MUL_N) ? DIV_N : MUL_N;
   localparam int ACC_W  = MUL_N + tbrl_pkg::IV_W;
   localparam int SUM_W  = ACC_W + 1;
   localparam int STEP_W = $clog2(OPW + 1);

   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [OPW-1:0]          opnd_ff, opnd_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   tbrl_pkg::unit_mode_type mode_ff, mode_in;

   logic             bit_in;
   logic             is_div;
   logic             qbit;
   logic [ACC_W-1:0] shifted;
   logic [ACC_W-1:0] ivx;
   logic [ACC_W-1:0] addend;
   logic [SUM_W-1:0] sum;

   assign busy     = (cnt_ff != '0);
   assign quotient = opnd_ff[DIV_N-1:0];
   assign product  = acc_ff;

   // one step per cycle: the shared adder subtracts for divide, accumulates for multiply
   always_comb begin
      is_div  = (mode_ff == tbrl_pkg::MODE_DIVIDE);
      bit_in  = opnd_ff[OPW-1];
      shifted = {acc_ff[ACC_W-2:0], is_div & bit_in};
      ivx     = ACC_W'(divisor);
      addend  = is_div ? ~ivx : (bit_in ? ivx : '0);
      sum     = {1'b0, shifted} + {1'b0, addend} + SUM_W'(is_div);

      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      qbit    = 1'b0;

      if (ctrl.start) begin
         acc_in  = '0;
         opnd_in = operand;
         mode_in = ctrl.mode;
         cnt_in  = (ctrl.mode == tbrl_pkg::MODE_DIVIDE) ? STEP_W'(DIV_N) : STEP_W'(MUL_N);
      end else if (busy) begin
         if (is_div) begin
            // remainder keeps the difference only when it did not borrow
            qbit   = sum[ACC_W];
            acc_in = qbit ? sum[ACC_W-1:0] : shifted;
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
         opnd_in = {opnd_ff[OPW-2:0], qbit};
         cnt_in  = cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      mode_ff <= mode_in;
   end

endmodule

>>> bench/token_bucket_checker.sv
// reply checker for the rate limiter: bucket prediction and per-field compare
`timescale 1ns / 1ps

module token_bucket_checker (
   input  logic                             clock,
   input  logic                             reset,
   tbrl_req_if                              req_ch,
   tbrl_rsp_if                              rsp_ch,
   input  logic                             csr_write_en,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               mismatch_count,
   output int                               outstanding,
   output int                               refusal_count
);

   localparam int          FRAC_BITS = 16;
   localparam logic [63:0] TIME_MAX  = (64'd1 << 48) - 64'd1;
   localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

   typedef struct packed {
      logic                            granted;
      logic [tbrl_pkg::OUT_TIME_W-1:0] wait_us;
   } grant_reply_type;

   // bucket copy and register copy
   logic [63:0]                 free_at;
   logic [63:0]                 banked;
   logic [tbrl_pkg::IV_W-1:0]   interval_reg;
   logic [tbrl_pkg::MAXP_W-1:0] ceiling_reg;

   grant_reply_type awaited_replies[$];
   grant_reply_type predicted;
   grant_reply_type oldest;

   // time sum that sticks at the top of the 48-bit range
   function automatic logic [63:0] time_add(logic [63:0] a, logic [63:0] b);
      return (b > TIME_MAX - a) ? TIME_MAX : a + b;
   endfunction

   // grant decision for one request; advances the bucket on a grant
   function automatic grant_reply_type grant_decision(tbrl_pkg::opcode_type op,
                                                      logic [tbrl_pkg::COUNT_W-1:0] count,
                                                      logic [tbrl_pkg::TIMEOUT_W-1:0] timeout_ms,
                                                      logic [tbrl_pkg::OUT_TIME_W-1:0] now_us);
      logic [63:0]     iv;
      logic [63:0]     now;
      logic [63:0]     cap;
      logic [63:0]     elapsed;
      logic [63:0]     whole;
      logic [63:0]     rem;
      logic [63:0]     sum;
      logic [63:0]     want;
      logic [63:0]     used;
      logic [63:0]     fresh;
      logic [63:0]     fresh_whole;
      logic [63:0]     part;
      logic [63:0]     push;
      grant_reply_type reply;
      iv = (interval_reg == '0) ? 64'd1 : 64'(interval_reg);
      now = 64'(now_us);
      reply.granted = 1'b0;
      reply.wait_us = '0;

      // try-acquire refused when the free time lies beyond the timeout
      if (op == tbrl_pkg::OP_TRY_ACQUIRE && free_at > now &&
          free_at - now > 64'(timeout_ms) * 64'(tbrl_pkg::US_PER_MS))
         return reply;

      // sync: refill from idle time, capped at the ceiling
      if (now > free_at) begin
         cap = 64'(ceiling_reg) << FRAC_BITS;
         elapsed = now - free_at;
         whole = elapsed / iv;
         rem = elapsed % iv;
         if (whole >= 64'(ceiling_reg)) begin
            banked = cap;
         end else begin
            sum = banked + (whole << FRAC_BITS) + ((rem << FRAC_BITS) / iv);
            banked = (sum < cap) ? sum : cap;
         end
         free_at = now;
      end

      reply.granted = 1'b1;
      reply.wait_us = (free_at > now) ? tbrl_pkg::OUT_TIME_W'(free_at - now) : '0;

      // banked permits first, the rest pushes the free time forward
      want = 64'(count) << FRAC_BITS;
      used = (want < banked) ? want : banked;
      fresh = want - used;
      fresh_whole = fresh >> FRAC_BITS;
      part = ((fresh & FRAC_MASK) * iv) >> FRAC_BITS;
      if (fresh_whole != 0 && iv > TIME_MAX / fresh_whole)
         push = TIME_MAX;
      else
         push = time_add(fresh_whole * iv, part);
      free_at = time_add(free_at, push);
      banked = banked - used;
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         free_at = '0;
         banked = '0;
         interval_reg = tbrl_pkg::INTERVAL_RESET;
         ceiling_reg = tbrl_pkg::MAX_STORED_RESET;
         awaited_replies.delete();
         mismatch_count = 0;
         refusal_count = 0;
         outstanding <= 0;
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               tbrl_pkg::CSR_INTERVAL:   interval_reg = csr_write_data[tbrl_pkg::IV_W-1:0];
               tbrl_pkg::CSR_MAX_STORED: ceiling_reg = csr_write_data[tbrl_pkg::MAXP_W-1:0];
               default: ;
            endcase
         end

         // reply transfer against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
               mismatch_count++;
               $display("%0t: reply with none pending: granted %0b wait_us %0d",
                        $time, rsp_ch.granted, rsp_ch.wait_us);
            end else begin
               oldest = awaited_replies.pop_front();
               if (!oldest.granted)
                  refusal_count++;
               if (rsp_ch.granted !== oldest.granted) begin
                  mismatch_count++;
                  $display("%0t: granted expected %0b actual %0b",
                           $time, oldest.granted, rsp_ch.granted);
               end
               if (rsp_ch.wait_us !== oldest.wait_us) begin
                  mismatch_count++;
                  $display("%0t: wait_us expected %0d actual %0d",
                           $time, oldest.wait_us, rsp_ch.wait_us);
               end
            end
         end

         // request transfer
         if (req_ch.valid && req_ch.ready) begin
            predicted = grant_decision(tbrl_pkg::opcode_type'(req_ch.opcode),
                                       req_ch.permit_count, req_ch.timeout_ms, req_ch.now_us);
            awaited_replies.push_back(predicted);
         end

         outstanding <= awaited_replies.size();
      end
   end

endmodule

>>> bench/tb.sv
// testbench top for the rate limiter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;

   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 150;
   localparam int          PHASE_ITEMS   = 160;
   localparam logic [47:0] TIME_TOP      = '1;

   // register settings and idle pattern of each random phase
   localparam logic [31:0] PHASE_IV [8] = '{32'd1000, 32'd1, 32'd1000000, 32'd37,
                                            32'hFFFFFFFF, 32'd250000, 32'd1000, 32'd7};
   localparam logic [15:0] PHASE_CEIL [8] = '{16'd8, 16'd65535, 16'd0, 16'd100,
                                              16'd2, 16'd3, 16'd1, 16'd40};
   localparam int SEND_IDLE [4] = '{0, 57, 0, 20};
   localparam int RECV_STALL [4] = '{0, 0, 57, 20};

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_en;
   logic [tbrl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tbrl_pkg::CSR_DATA_W-1:0]  csr_write_data;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;
   int          requests_sent = 0;
   int          settings_used = 0;
   int          mismatches;
   int          outstanding;
   int          refusals;
   logic [63:0] sim_now;
   logic [31:0] cur_interval = tbrl_pkg::INTERVAL_RESET;
   logic [15:0] cur_ceiling = tbrl_pkg::MAX_STORED_RESET;

   tbrl_req_if req_ch ();
   tbrl_rsp_if rsp_ch ();

   token_bucket_rate_limiter_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   token_bucket_checker bucket_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatches),
      .outstanding    (outstanding),
      .refusal_count  (refusals)
   );

   always #5 clock = ~clock;

   // cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // reply side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // uniform value in lo..hi over 64 bits
   function automatic logic [63:0] pick(logic [63:0] lo, logic [63:0] hi);
      if (hi <= lo)
         return lo;
      return lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
   endfunction

   // one request transfer, with a random gap ahead of it
   task automatic send_request(tbrl_pkg::opcode_type op, logic [15:0] count,
                               logic [30:0] timeout, logic [47:0] now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.permit_count <= count;
      req_ch.timeout_ms <= timeout;
      req_ch.now_us <= now;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // hold off the sender until every reply is in
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write both registers while the block is idle
   task automatic program_bucket(logic [31:0] iv, logic [15:0] ceiling);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= tbrl_pkg::CSR_INTERVAL;
      csr_write_data <= iv;
      @(posedge clock);
      csr_index <= tbrl_pkg::CSR_MAX_STORED;
      csr_write_data <= tbrl_pkg::CSR_DATA_W'(ceiling);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_interval = iv;
      cur_ceiling = ceiling;
      settings_used++;
   endtask

   // random request scaled to the interval so refills and waits both show up
   task automatic send_random_item();
      logic [63:0] iv;
      logic [63:0] count_hi;
      logic [63:0] count;
      logic [63:0] step;
      logic [63:0] now;
      logic [63:0] timeout;
      int          roll;
      iv = (cur_interval == 0) ? 64'd1 : 64'(cur_interval);
      count_hi = (64'd1 << 26) / iv;
      if (count_hi == 0) count_hi = 1;
      if (count_hi > 65535) count_hi = 65535;

      roll = $urandom_range(0, 99);
      if (roll < 60)
         count = pick(1, 4);
      else if (roll < 85)
         count = pick(1, (count_hi < 64'(cur_ceiling) + 4) ? count_hi : 64'(cur_ceiling) + 4);
      else
         count = pick(1, count_hi);

      roll = $urandom_range(0, 99);
      if (roll < 35)
         step = pick(0, iv / 2);
      else if (roll < 65)
         step = pick(iv, 4 * iv);
      else if (roll < 85)
         step = pick(0, 32 * iv);
      else
         step = pick(0, (64'd1 << 26) + 64 * iv);
      if ($urandom_range(0, 3) == 0)
         step = step - step % 1000;
      // an occasional look back in time
      if (roll >= 95) begin
         now = sim_now - pick(0, (sim_now < 8 * iv) ? sim_now : 8 * iv);
      end else begin
         sim_now = sim_now + step;
         now = sim_now;
      end

      roll = $urandom_range(0, 99);
      if (roll < 30)
         timeout = 0;
      else if (roll < 70)
         timeout = pick(0, 4 * iv / 1000 + 4);
      else if (roll < 90)
         timeout = pick(0, 64'h7FFFFFFF);
      else
         timeout = pick(0, 64);

      if ($urandom_range(0, 99) == 0)
         drain();
      send_request(tbrl_pkg::opcode_type'($urandom_range(0, 1)), 16'(count), 31'(timeout),
                   48'(now));
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= tbrl_pkg::OP_ACQUIRE;
      req_ch.permit_count <= '0;
      req_ch.timeout_ms <= '0;
      req_ch.now_us <= '0;
      csr_write_en <= 1'b0;
      csr_index <= tbrl_pkg::CSR_INTERVAL;
      csr_write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // defaults: extremes of count and timeout, exact timeout boundary
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, 48'd0);
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd65535, 31'd0, 48'd0);
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'd0, 48'd100);
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'h7FFFFFFF, 48'd100);
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'd5000, 48'd65532000000);
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'd5000, 48'd65532999999);
      // zero permits after idle time
      sim_now = 64'd65540500000;
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd0, 31'd0, 48'(sim_now));

      // partial refill, spend of banked permits, refill up to the ceiling
      program_bucket(32'd1000, 16'd65535);
      sim_now = sim_now + 1500;
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, 48'(sim_now));
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd2, 31'd0, 48'(sim_now));
      sim_now = sim_now + 70_000_000;
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd3, 31'd0, 48'(sim_now));

      // lowered ceiling: cut only at the next sync
      program_bucket(32'd1000, 16'd10);
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, 48'(sim_now));
      sim_now = sim_now + 1;
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, 48'(sim_now));

      // zero interval acts as one
      program_bucket(32'd0, 16'd3);
      sim_now = sim_now + 10;
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd5, 31'd0, 48'(sim_now));
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'd0, 48'(sim_now));

      // random phases across settings and idle patterns
      for (int p = 0; p < 8; p++) begin
         program_bucket(PHASE_IV[p], PHASE_CEIL[p]);
         send_idle_pct = SEND_IDLE[p % 4];
         stall_pct = RECV_STALL[p % 4];
         repeat (PHASE_ITEMS) send_random_item();
      end

      // late time and widest interval, then next free time saturation
      program_bucket(32'hFFFFFFFF, 16'd65535);
      send_idle_pct = 20;
      stall_pct = 20;
      sim_now = pick(64'd1 << 47, (64'd1 << 47) + (64'd1 << 46));
      repeat (60) send_random_item();
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd65535, 31'd0, 48'(sim_now));
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd65535, 31'd0, 48'(sim_now));
      send_request(tbrl_pkg::OP_TRY_ACQUIRE, 16'd1, 31'h7FFFFFFF, 48'(sim_now));
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, TIME_TOP);
      send_request(tbrl_pkg::OP_ACQUIRE, 16'd1, 31'd0, 48'd0);
      repeat (12)
         send_request(tbrl_pkg::opcode_type'($urandom_range(0, 1)), 16'(pick(1, 65535)),
                      31'(pick(0, 64'h7FFFFFFF)), 48'(pick(0, 64'(TIME_TOP))));

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests over %0d register settings, %0d try-acquires refused",
               requests_sent, settings_used, refusals);
      $display("ran with no idling, sender gaps, receiver stalls and both, up to a full bucket");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
